// ===== sv/rotate_point_about_pivot_core_assert.svh =====
// Assertion macros used by the top level of the rotate-about-pivot RTL.
`ifndef ROTATE_POINT_ABOUT_PIVOT_CORE_ASSERT_SVH
`define ROTATE_POINT_ABOUT_PIVOT_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RPAP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that cons holds a fixed number of cycles after ante.
`define RPAP_ASSERT_AFTER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== sv/rpap_pkg.sv =====
// Shared types, constants and the arctangent table of the rotate-about-pivot core.
package rpap_pkg;

    localparam int COORD_W      = 24;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PHASE_W      = 32;
    localparam int GAIN_W       = 32;
    localparam int FRAC_W       = 30;
    localparam int X_W          = 58;
    localparam int Z_W          = 33;
    localparam int CORDIC_STEPS = 24;

    // 1/K in Q2.30, and pi/2 in Q2.30
    localparam logic signed [GAIN_W-1:0] INV_GAIN    = 32'sd652032874;
    localparam logic signed [GAIN_W-1:0] PI_HALF_Q30 = 32'sd1686629713;

    // One CORDIC stage worth of data, travelling with its valid bit
    typedef struct packed {
        logic                      valid;
        logic signed [X_W-1:0]     x;
        logic signed [X_W-1:0]     y;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
    } t_cordic_bus;

    // atan(2^-step) in Q2.30
    function automatic logic signed [Z_W-1:0] atan_q30(input int step);
        logic signed [Z_W-1:0] a;
        unique case (step)
            0:       a = 33'sd843314856;
            1:       a = 33'sd497837829;
            2:       a = 33'sd263043836;
            3:       a = 33'sd133525158;
            4:       a = 33'sd67021686;
            5:       a = 33'sd33543515;
            6:       a = 33'sd16775850;
            7:       a = 33'sd8388437;
            8:       a = 33'sd4194282;
            9:       a = 33'sd2097149;
            10:      a = 33'sd1048575;
            11:      a = 33'sd524287;
            12:      a = 33'sd262143;
            13:      a = 33'sd131071;
            14:      a = 33'sd65535;
            15:      a = 33'sd32767;
            16:      a = 33'sd16383;
            17:      a = 33'sd8191;
            18:      a = 33'sd4095;
            19:      a = 33'sd2047;
            20:      a = 33'sd1023;
            21:      a = 33'sd511;
            22:      a = 33'sd255;
            23:      a = 33'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== sv/rpap_cordic_stage.sv =====
// One registered CORDIC micro-rotation step with a fixed shift.
module rpap_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rpap_pkg::t_cordic_bus i_bus,
    output rpap_pkg::t_cordic_bus o_bus
);
    import rpap_pkg::*;

    logic                      r_valid;
    logic signed [X_W-1:0]     r_x, n_x;
    logic signed [X_W-1:0]     r_y, n_y;
    logic signed [Z_W-1:0]     r_z, n_z;
    logic signed [COORD_W-1:0] r_pivot_x;
    logic signed [COORD_W-1:0] r_pivot_y;
    logic signed [X_W-1:0]     w_xs;
    logic signed [X_W-1:0]     w_ys;
    logic signed [Z_W-1:0]     w_atan;

    // Rotate toward zero residual angle
    always_comb begin
        w_xs   = $signed(i_bus.x) >>> STEP;
        w_ys   = $signed(i_bus.y) >>> STEP;
        w_atan = atan_q30(STEP);
        if (!i_bus.z[Z_W-1]) begin
            n_x = i_bus.x - w_ys;
            n_y = i_bus.y + w_xs;
            n_z = i_bus.z - w_atan;
        end else begin
            n_x = i_bus.x + w_ys;
            n_y = i_bus.y - w_xs;
            n_z = i_bus.z + w_atan;
        end
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_pivot_x <= i_bus.pivot_x;
        r_pivot_y <= i_bus.pivot_y;
    end

    assign o_bus = '{valid: r_valid, x: r_x, y: r_y, z: r_z,
                     pivot_x: r_pivot_x, pivot_y: r_pivot_y};

endmodule

// ===== sv/rotate_point_about_pivot_core.sv =====
// Top level of the pipelined point-about-pivot rotator.
//
// Rotates a Q15.8 point counterclockwise about a Q15.8 pivot by a binary
// angle (2^ANGLE_BITS units per turn), rounding and saturating the result.
// Takes one request every cycle (busy is always low) and delivers each result,
// flagged by o_valid for one cycle, in request order. The pipeline is made of
// the 24 CORDIC steps, one register stage each, plus three front stages
// (offset, quarter-turn, gain multiply) and two back stages (rounding, pivot
// add with saturation). The receiver cannot stall the pipeline, so results
// must be captured when o_valid is high.
`include "rotate_point_about_pivot_core_assert.svh"

module rotate_point_about_pivot_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rpap_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpap_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [rpap_pkg::COORD_W-1:0] i_pivot_x,
    input  logic signed [rpap_pkg::COORD_W-1:0] i_pivot_y,
    input  logic        [ANGLE_BITS-1:0]        i_turn_angle,
    output logic                                o_valid,
    output logic signed [rpap_pkg::COORD_W-1:0] o_rotated_x,
    output logic signed [rpap_pkg::COORD_W-1:0] o_rotated_y
);
    import rpap_pkg::*;

    localparam int LATENCY = 3 + CORDIC_STEPS + 2;
    localparam int RND_W   = X_W - FRAC_W;
    localparam int SUM_W   = RND_W + 1;
    localparam int PROD_W  = DIFF_W + GAIN_W;
    localparam int ZPROD_W = PHASE_W + GAIN_W;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(1 << (COORD_W - 1));
    localparam logic signed [X_W-1:0]   RND_HALF = X_W'(1) <<< (FRAC_W - 1);

    // Stage 1: offset and angle split
    logic                       r_s1_valid;
    logic signed [DIFF_W-1:0]   r_s1_dx, r_s1_dy;
    logic        [1:0]          r_s1_quad;
    logic signed [PHASE_W-1:0]  r_s1_res;
    logic signed [COORD_W-1:0]  r_s1_pivot_x, r_s1_pivot_y;
    logic        [PHASE_W-1:0]  w_phase;
    logic        [PHASE_W-1:0]  w_phase_rnd;

    // Stage 2: quarter-turn pre-rotation
    logic                       r_s2_valid;
    logic signed [DIFF_W-1:0]   r_s2_x, r_s2_y;
    logic signed [DIFF_W-1:0]   n_s2_x, n_s2_y;
    logic signed [PHASE_W-1:0]  r_s2_res;
    logic signed [COORD_W-1:0]  r_s2_pivot_x, r_s2_pivot_y;

    // Stage 3: gain pre-scale and residual angle to radians
    logic                       r_s3_valid;
    logic signed [X_W-1:0]      r_s3_x, r_s3_y;
    logic signed [Z_W-1:0]      r_s3_z;
    logic signed [COORD_W-1:0]  r_s3_pivot_x, r_s3_pivot_y;
    logic signed [PROD_W-1:0]   w_prod_x, w_prod_y;
    logic signed [ZPROD_W-1:0]  w_prod_z;

    // CORDIC chain
    t_cordic_bus                w_bus [CORDIC_STEPS+1];

    // Rounding stage
    logic                       r_rd_valid;
    logic signed [RND_W-1:0]    r_rd_x, r_rd_y;
    logic signed [COORD_W-1:0]  r_rd_pivot_x, r_rd_pivot_y;
    logic signed [X_W-1:0]      w_rnd_x, w_rnd_y;

    // Output stage
    logic                       r_out_valid;
    logic signed [COORD_W-1:0]  r_out_x, r_out_y;
    logic signed [COORD_W-1:0]  n_out_x, n_out_y;
    logic signed [SUM_W-1:0]    w_sum_x, w_sum_y;

    assign busy = 1'b0;

    // Split the phase into a nearest quadrant and a signed residual
    assign w_phase     = {i_turn_angle, {(PHASE_W - ANGLE_BITS){1'b0}}};
    assign w_phase_rnd = w_phase + (PHASE_W'(1) << (PHASE_W - 3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_rd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= start & ~busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_rd_valid <= w_bus[CORDIC_STEPS].valid;
            r_out_valid <= r_rd_valid;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        r_s1_dx      <= DIFF_W'(i_point_x) - DIFF_W'(i_pivot_x);
        r_s1_dy      <= DIFF_W'(i_point_y) - DIFF_W'(i_pivot_y);
        r_s1_quad    <= w_phase_rnd[PHASE_W-1 -: 2];
        r_s1_res     <= $signed(w_phase - {w_phase_rnd[PHASE_W-1 -: 2],
                                           {(PHASE_W - 2){1'b0}}});
        r_s1_pivot_x <= i_pivot_x;
        r_s1_pivot_y <= i_pivot_y;
    end

    // Apply the exact quarter-turn
    always_comb begin
        unique case (r_s1_quad)
            QUAD_0: begin
                n_s2_x = r_s1_dx;
                n_s2_y = r_s1_dy;
            end
            QUAD_90: begin
                n_s2_x = -r_s1_dy;
                n_s2_y = r_s1_dx;
            end
            QUAD_180: begin
                n_s2_x = -r_s1_dx;
                n_s2_y = -r_s1_dy;
            end
            QUAD_270: begin
                n_s2_x = r_s1_dy;
                n_s2_y = -r_s1_dx;
            end
            default: begin
                n_s2_x = r_s1_dx;
                n_s2_y = r_s1_dy;
            end
        endcase
    end

    // Stage 2 payload
    always_ff @(posedge i_clk) begin
        r_s2_x       <= n_s2_x;
        r_s2_y       <= n_s2_y;
        r_s2_res     <= r_s1_res;
        r_s2_pivot_x <= r_s1_pivot_x;
        r_s2_pivot_y <= r_s1_pivot_y;
    end

    // Multiply by 1/K and by pi/2
    assign w_prod_x = PROD_W'(r_s2_x) * PROD_W'(INV_GAIN);
    assign w_prod_y = PROD_W'(r_s2_y) * PROD_W'(INV_GAIN);
    assign w_prod_z = ZPROD_W'(r_s2_res) * ZPROD_W'(PI_HALF_Q30);

    // Stage 3 payload
    always_ff @(posedge i_clk) begin
        r_s3_x       <= X_W'(w_prod_x);
        r_s3_y       <= X_W'(w_prod_y);
        r_s3_z       <= w_prod_z[FRAC_W + Z_W - 1 : FRAC_W];
        r_s3_pivot_x <= r_s2_pivot_x;
        r_s3_pivot_y <= r_s2_pivot_y;
    end

    assign w_bus[0] = '{valid: r_s3_valid, x: r_s3_x, y: r_s3_y, z: r_s3_z,
                        pivot_x: r_s3_pivot_x, pivot_y: r_s3_pivot_y};

    // One registered micro-rotation per step
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        rpap_cordic_stage #(
            .STEP (g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_bus[g]),
            .o_bus   (w_bus[g+1])
        );
    end

    // Round off the fraction bits
    assign w_rnd_x = w_bus[CORDIC_STEPS].x + RND_HALF;
    assign w_rnd_y = w_bus[CORDIC_STEPS].y + RND_HALF;

    always_ff @(posedge i_clk) begin
        r_rd_x       <= w_rnd_x[X_W-1:FRAC_W];
        r_rd_y       <= w_rnd_y[X_W-1:FRAC_W];
        r_rd_pivot_x <= w_bus[CORDIC_STEPS].pivot_x;
        r_rd_pivot_y <= w_bus[CORDIC_STEPS].pivot_y;
    end

    // Add the pivot back and saturate
    assign w_sum_x = SUM_W'(r_rd_x) + SUM_W'(r_rd_pivot_x);
    assign w_sum_y = SUM_W'(r_rd_y) + SUM_W'(r_rd_pivot_y);

    always_comb begin
        priority if (w_sum_x > SUM_MAX) begin
            n_out_x = COORD_W'(SUM_MAX);
        end else if (w_sum_x < SUM_MIN) begin
            n_out_x = COORD_W'(SUM_MIN);
        end else begin
            n_out_x = COORD_W'(w_sum_x);
        end
        priority if (w_sum_y > SUM_MAX) begin
            n_out_y = COORD_W'(SUM_MAX);
        end else if (w_sum_y < SUM_MIN) begin
            n_out_y = COORD_W'(SUM_MIN);
        end else begin
            n_out_y = COORD_W'(w_sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign o_valid     = r_out_valid;
    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;

    // Every request yields a result after the fixed latency
    `RPAP_ASSERT_AFTER(a_req_to_result, start && !busy, LATENCY, o_valid,
        "request did not produce a result after the pipeline latency")

    // No result appears without a matching request
    `RPAP_ASSERT_NOW(a_no_spurious_result, o_valid, $past(start && !busy, LATENCY),
        "result strobe without a matching request")

    // A point on the pivot stays on the pivot
    `RPAP_ASSERT_NOW(a_pivot_fixed,
        o_valid && $past(i_point_x == i_pivot_x && i_point_y == i_pivot_y, LATENCY),
        o_rotated_x == $past(i_pivot_x, LATENCY) && o_rotated_y == $past(i_pivot_y, LATENCY),
        "point at the pivot moved under rotation")

endmodule
